// ----- rtl/swfd_pkg.sv -----
// Shared types and constants for the scale weight frame decoder.
`default_nettype none
package swfd_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [BYTE_W-1:0] FRAME_HEAD = 8'hA7;
	localparam logic [BYTE_W-1:0] FRAME_TYPE = 8'h0E;
	localparam logic [BYTE_W-1:0] FRAME_TAIL = 8'h7A;

	localparam logic [POS_W-1:0] POS_HEAD      = 5'd0;
	localparam logic [POS_W-1:0] POS_SUM_FIRST = 5'd2;
	localparam logic [POS_W-1:0] POS_TYPE      = 5'd3;
	localparam logic [POS_W-1:0] POS_W_HIGH    = 5'd9;
	localparam logic [POS_W-1:0] POS_W_LOW     = 5'd10;
	localparam logic [POS_W-1:0] POS_SUM_LAST  = 5'd17;
	localparam logic [POS_W-1:0] POS_CHECKSUM  = 5'd18;
	localparam logic [POS_W-1:0] POS_TAIL      = 5'd19;
	localparam logic [POS_W-1:0] POS_LEN       = 5'd20;
	localparam logic [POS_W-1:0] POS_MAX       = 5'd31;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FRAME = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_SUM   = 2'd2;

	// One input word as held in the input register.
	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic              last_byte;
	} in_word_t;

	// One decoded result.
	typedef struct packed {
		logic [STATUS_W-1:0]        status;
		logic signed [WEIGHT_W-1:0] weight_decigrams;
	} result_t;

	// Handshake control between the input stage and the rest of the pipe.
	typedef struct packed {
		logic valid;
		logic advance;
	} pipe_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/swfd_in_stage.sv -----
// Input register for incoming notification words.
`default_nettype none
module swfd_in_stage (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output      logic                           s_axis_tready,
	input  wire logic [swfd_pkg::BYTE_W-1:0]    s_axis_tdata,  // byte_value
	input  wire logic                           s_axis_tlast,  // last_byte
	input  wire logic                           out_free,
	output      swfd_pkg::in_word_t             word_s1,
	output      swfd_pkg::pipe_ctrl_t           ctrl
);

	logic valid_s1;
	logic advance;

	// A final word needs room in the result register; other words always move on.
	assign advance       = valid_s1 && (!word_s1.last_byte || out_free);
	assign s_axis_tready = !valid_s1 || advance;
	assign ctrl.valid    = valid_s1;
	assign ctrl.advance  = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			word_s1.byte_value <= s_axis_tdata;
			word_s1.last_byte  <= s_axis_tlast;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/swfd_frame_check.sv -----
// Per-word frame checks, running checksum and weight capture.
`default_nettype none
module swfd_frame_check (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire swfd_pkg::in_word_t   word_s1,
	input  wire logic                 advance,
	output      swfd_pkg::result_t    result
);

	logic [swfd_pkg::POS_W-1:0]  pos_q;
	logic [swfd_pkg::BYTE_W-1:0] sum_q;
	logic [swfd_pkg::BYTE_W-1:0] w_high_q;
	logic [swfd_pkg::BYTE_W-1:0] w_low_q;
	logic                        ferr_q;
	logic                        cerr_q;

	logic [swfd_pkg::BYTE_W-1:0] b;
	logic [swfd_pkg::BYTE_W-1:0] sum_d;
	logic [swfd_pkg::POS_W-1:0]  pos_d;
	logic                        ferr_d;
	logic                        cerr_d;
	logic                        ferr_fin;

	assign b = word_s1.byte_value;

	always_comb begin
		ferr_d = ferr_q;
		cerr_d = cerr_q;
		sum_d  = sum_q;
		if (pos_q == swfd_pkg::POS_HEAD && b != swfd_pkg::FRAME_HEAD) ferr_d = 1'b1;
		if (pos_q == swfd_pkg::POS_TYPE && b != swfd_pkg::FRAME_TYPE) ferr_d = 1'b1;
		if (pos_q == swfd_pkg::POS_TAIL && b != swfd_pkg::FRAME_TAIL) ferr_d = 1'b1;
		if (pos_q >= swfd_pkg::POS_LEN) ferr_d = 1'b1;
		if (pos_q >= swfd_pkg::POS_SUM_FIRST && pos_q <= swfd_pkg::POS_SUM_LAST) begin
			sum_d = sum_q + b;
		end
		if (pos_q == swfd_pkg::POS_CHECKSUM && b != sum_q) cerr_d = 1'b1;
		pos_d = (pos_q == swfd_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;
	end

	// A frame that ends anywhere but the footer position is not a weight frame.
	assign ferr_fin = ferr_d || (pos_q != swfd_pkg::POS_TAIL);

	always_comb begin
		result.weight_decigrams = '0;
		priority if (ferr_fin) begin
			result.status = swfd_pkg::STATUS_NOT_FRAME;
		end else if (cerr_d) begin
			result.status = swfd_pkg::STATUS_BAD_SUM;
		end else begin
			result.status           = swfd_pkg::STATUS_OK;
			result.weight_decigrams = {w_high_q, w_low_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			w_high_q <= '0;
			w_low_q  <= '0;
			ferr_q   <= 1'b0;
			cerr_q   <= 1'b0;
		end else if (advance) begin
			if (word_s1.last_byte) begin
				pos_q    <= '0;
				sum_q    <= '0;
				w_high_q <= '0;
				w_low_q  <= '0;
				ferr_q   <= 1'b0;
				cerr_q   <= 1'b0;
			end else begin
				pos_q  <= pos_d;
				sum_q  <= sum_d;
				ferr_q <= ferr_d;
				cerr_q <= cerr_d;
				if (pos_q == swfd_pkg::POS_W_HIGH) w_high_q <= b;
				if (pos_q == swfd_pkg::POS_W_LOW) w_low_q <= b;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/swfd_out_stage.sv -----
// Result register driving the output word channel.
`default_nettype none
module swfd_out_stage (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                load,
	input  wire swfd_pkg::result_t                   result,
	output      logic                                out_free,
	output      logic                                m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output      logic [swfd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata  // status, weight_decigrams
);

	logic              valid_q;
	swfd_pkg::result_t res_q;

	assign out_free      = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {6'b0, res_q.weight_decigrams, res_q.status};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/scale_weight_frame_decoder.sv -----
// Top level of the scale weight frame decoder.
//
// The block takes a scale notification one byte per word on the slave
// stream (s_axis_*): tdata carries the byte, tlast marks the final byte.
// For every notification it returns exactly one word on the master stream
// (m_axis_*): tdata[1:0] is the status (0 weight valid, 1 not a weight
// frame, 2 bad checksum) and tdata[17:2] is the signed weight in tenths of
// a gram, zero unless the status is 0. Bits 23:18 are zero.
// Each word is first captured in an input register; the frame checks run
// between that register and the result register. A result therefore shows
// on m_axis_tvalid once its last byte has moved on into the result register.
// Throughput is one byte per cycle unless a final byte stalls, set by the
// single input register and the combinational checks; a new notification
// may start the cycle right after the previous one's last byte.
// When the receiver stalls, the pending result stays in the result register
// while non-final bytes keep flowing; only a final byte that finds the
// result register still full waits in the input register and lowers
// s_axis_tready.
// Reset (arst_n low) drops both valid flags and clears the frame state, so
// the next accepted byte is taken as byte 0 of a new notification.
`default_nettype none
module scale_weight_frame_decoder (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output      logic                                s_axis_tready,
	input  wire logic [swfd_pkg::BYTE_W-1:0]         s_axis_tdata,  // byte_value
	input  wire logic                                s_axis_tlast,  // last_byte
	output      logic                                m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output      logic [swfd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // status, weight_decigrams
);

	swfd_pkg::in_word_t   word_s1;
	swfd_pkg::pipe_ctrl_t ctrl;
	swfd_pkg::result_t    result;
	logic                 out_free;
	logic                 load;

	// A result is produced exactly when the final byte leaves the input register.
	assign load = ctrl.advance && word_s1.last_byte;

	swfd_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.out_free      (out_free),
		.word_s1       (word_s1),
		.ctrl          (ctrl)
	);

	swfd_frame_check u_frame_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.word_s1 (word_s1),
		.advance (ctrl.advance),
		.result  (result)
	);

	swfd_out_stage u_out_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.result        (result),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// The status code never takes the unused value.
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("unused status code on output");

	// A rejected frame carries a zero weight.
	a_weight_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] != swfd_pkg::STATUS_OK)
		|-> m_axis_tdata[17:2] == 16'd0)
		else $error("nonzero weight with failing status");

	// The input side only stalls while a final byte is held.
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> ctrl.valid && word_s1.last_byte)
		else $error("input stalled without a held final byte");

	// A final byte that moves on always yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_axis_tvalid)
		else $error("final byte produced no result");

endmodule
`default_nettype wire

// ----- tb/sv/scale_weight_frame_decoder_checker.sv -----
// Scoreboard for the scale weight frame decoder: predicts each result word and compares it.
module scale_weight_frame_decoder_checker
	import swfd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	input  wire logic                   s_axis_tready,
	input  wire logic [BYTE_W-1:0]      s_axis_tdata,  // byte_value
	input  wire logic                   s_axis_tlast,  // last_byte
	input  wire logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,  // status, weight_decigrams
	output int unsigned                 fail_count,
	output int unsigned                 pending
);

	// Decoder state as the block should hold it between words.
	logic [POS_W-1:0]  frame_pos;
	logic [BYTE_W-1:0] frame_sum;
	logic [BYTE_W-1:0] weight_hi;
	logic [BYTE_W-1:0] weight_lo;
	logic              fmt_err;
	logic              sum_err;

	result_t expected_results[$];

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic clear_frame();
		frame_pos = '0;
		frame_sum = '0;
		weight_hi = '0;
		weight_lo = '0;
		fmt_err   = 1'b0;
		sum_err   = 1'b0;
	endtask

	// Runs the frame checks for one accepted byte; a final byte yields one expected result.
	task automatic decode_byte(input logic [BYTE_W-1:0] value, input logic last);
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] sum;
		logic              ferr;
		logic              cerr;
		result_t           res;
		pos  = frame_pos;
		sum  = frame_sum;
		ferr = fmt_err;
		cerr = sum_err;
		if (pos == POS_HEAD && value != FRAME_HEAD)
			ferr = 1'b1;
		if (pos == POS_TYPE && value != FRAME_TYPE)
			ferr = 1'b1;
		if (pos >= POS_SUM_FIRST && pos <= POS_SUM_LAST)
			sum = sum + value;
		if (pos == POS_W_HIGH)
			weight_hi = value;
		if (pos == POS_W_LOW)
			weight_lo = value;
		if (pos == POS_CHECKSUM && value != sum)
			cerr = 1'b1;
		if (pos == POS_TAIL && value != FRAME_TAIL)
			ferr = 1'b1;
		if (pos >= POS_LEN)
			ferr = 1'b1;
		if (last) begin
			if (pos != POS_TAIL)
				ferr = 1'b1;
			res.weight_decigrams = '0;
			if (ferr) begin
				res.status = STATUS_NOT_FRAME;
			end else if (cerr) begin
				res.status = STATUS_BAD_SUM;
			end else begin
				res.status = STATUS_OK;
				res.weight_decigrams = {weight_hi, weight_lo};
			end
			expected_results.push_back(res);
			clear_frame();
		end else begin
			frame_sum = sum;
			fmt_err   = ferr;
			sum_err   = cerr;
			frame_pos = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
		end
	endtask

	task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
		result_t                    want;
		logic [STATUS_W-1:0]        got_status;
		logic signed [WEIGHT_W-1:0] got_weight;
		got_status = word[STATUS_W-1:0];
		got_weight = word[STATUS_W+WEIGHT_W-1:STATUS_W];
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result word %h with no notification pending", word));
		end else begin
			want = expected_results.pop_front();
			if (got_status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
			if (got_weight !== want.weight_decigrams)
				report_mismatch($sformatf("weight %0d, expected %0d", got_weight,
					want.weight_decigrams));
			if (word[OUT_TDATA_W-1:STATUS_W+WEIGHT_W] !== '0)
				report_mismatch($sformatf("padding bits nonzero in word %h", word));
		end
	endtask

	// The result leaving at an edge is always older than a byte taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			expected_results.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata, s_axis_tlast);
			pending = expected_results.size();
		end
	end

endmodule

// ----- tb/sv/scale_weight_frame_decoder_tb.sv -----
// Testbench top for the scale weight frame decoder: clock, reset, stimulus and verdict.
module scale_weight_frame_decoder_tb;
	import swfd_pkg::*;

	localparam int unsigned RANDOM_BYTES   = 320;
	localparam int unsigned MIN_NOTES      = 8;
	localparam int unsigned LONG_HOLD      = 80;
	localparam int unsigned DRAIN_CYCLES   = 10;
	localparam int unsigned TIMEOUT_CYCLES = 200000;

	// Ways a well-formed frame is broken on purpose.
	typedef enum int unsigned {
		FAULT_HEAD,
		FAULT_TYPE,
		FAULT_TAIL,
		FAULT_SUM,
		FAULT_HEAD_AND_SUM,
		FAULT_SHORT,
		FAULT_LONG
	} fault_e;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [BYTE_W-1:0]      s_axis_tdata  = '0;  // byte_value
	logic                   s_axis_tlast  = 1'b0; // last_byte
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // status, weight_decigrams

	int unsigned fail_count;
	int unsigned pending;

	logic [BYTE_W-1:0] note[$];  // notification being built or sent
	bit                src_idle;
	bit                sink_idle;
	bit                sink_hold_req;
	int unsigned       bytes_sent;

	scale_weight_frame_decoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	scale_weight_frame_decoder_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(2 * TIMEOUT_CYCLES);
		$display("Some tests failed");
		$finish;
	end

	// Receiver: either a long hold-off on request, a short random stall, or ready.
	initial begin
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				sink_hold_req = 1'b0;
			end else if (sink_idle && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offers one word and returns at the edge where it is taken.
	task automatic send_word(input logic [BYTE_W-1:0] value, input logic last);
		if (src_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_note();
		foreach (note[i])
			send_word(note[i], i == note.size() - 1);
	endtask

	// Stops offering and waits until every notification sent has been answered.
	task automatic wait_all_answered();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	task automatic seal_checksum();
		logic [BYTE_W-1:0] sum;
		sum = '0;
		for (int i = POS_SUM_FIRST; i <= POS_SUM_LAST; i++)
			sum = sum + note[i];
		note[POS_CHECKSUM] = sum;
	endtask

	task automatic build_frame(input logic [WEIGHT_W-1:0] weight);
		note.delete();
		repeat (POS_LEN)
			note.push_back(BYTE_W'($urandom_range(0, 255)));
		note[POS_HEAD]   = FRAME_HEAD;
		note[POS_TYPE]   = FRAME_TYPE;
		note[POS_W_HIGH] = weight[15:8];
		note[POS_W_LOW]  = weight[7:0];
		note[POS_TAIL]   = FRAME_TAIL;
		seal_checksum();
	endtask

	task automatic build_noise(input int unsigned max_len);
		note.delete();
		repeat ($urandom_range(1, max_len))
			note.push_back(BYTE_W'($urandom_range(0, 255)));
		// Half the time the junk starts like a real frame.
		if ($urandom_range(0, 1))
			note[POS_HEAD] = FRAME_HEAD;
	endtask

	// XOR with a nonzero mask so the broken byte always differs from the good one.
	task automatic mangle_frame(input fault_e fault);
		case (fault)
			FAULT_HEAD: note[POS_HEAD] ^= BYTE_W'($urandom_range(1, 255));
			FAULT_TYPE: begin
				note[POS_TYPE] ^= BYTE_W'($urandom_range(1, 255));
				seal_checksum();
			end
			FAULT_TAIL: note[POS_TAIL] ^= BYTE_W'($urandom_range(1, 255));
			FAULT_SUM:  note[POS_CHECKSUM] ^= BYTE_W'($urandom_range(1, 255));
			FAULT_HEAD_AND_SUM: begin
				note[POS_HEAD]     ^= BYTE_W'($urandom_range(1, 255));
				note[POS_CHECKSUM] ^= BYTE_W'($urandom_range(1, 255));
			end
			FAULT_SHORT: repeat ($urandom_range(1, 19)) void'(note.pop_back());
			FAULT_LONG:  repeat ($urandom_range(1, 16))
				note.push_back(BYTE_W'($urandom_range(0, 255)));
			default: ;
		endcase
	endtask

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 11))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return WEIGHT_W'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// Mostly good frames with random content, some broken frames, some junk.
	task automatic build_random_note();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			build_frame(pick_weight());
		end else if (pick < 88) begin
			build_frame(pick_weight());
			mangle_frame(fault_e'($urandom_range(FAULT_HEAD, FAULT_LONG)));
		end else begin
			build_noise(36);
		end
	endtask

	initial begin
		int unsigned random_start;
		int unsigned notes;
		src_idle      = 1'b1;
		sink_idle     = 1'b1;
		sink_hold_req = 1'b0;
		bytes_sent    = 0;
		wait (arst_n);
		@(posedge clk);

		// Directed: weight extremes, each fault, one-byte notes and a very long one.
		build_frame(16'h0000);
		send_note();
		build_frame(16'h7FFF);
		send_note();
		build_frame(16'h8000);
		send_note();
		build_frame(16'hFFFF);
		send_note();
		for (int f = FAULT_HEAD; f <= FAULT_LONG; f++) begin
			build_frame(pick_weight());
			mangle_frame(fault_e'(f));
			send_note();
		end
		note.delete();
		note.push_back(8'h00);
		send_note();
		note.delete();
		note.push_back(8'hFF);
		send_note();
		note.delete();
		note.push_back(FRAME_HEAD);
		send_note();
		// Forty bytes drive the position counter into saturation.
		build_frame(pick_weight());
		repeat (20)
			note.push_back(BYTE_W'($urandom_range(0, 255)));
		send_note();
		wait_all_answered();

		random_start = bytes_sent;
		notes = 0;
		while (bytes_sent - random_start < RANDOM_BYTES || notes < MIN_NOTES) begin
			if (bytes_sent - random_start > RANDOM_BYTES * 4 / 5) begin
				src_idle  = 1'b0;
				sink_idle = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				src_idle  = $urandom_range(0, 2) != 0;
				sink_idle = $urandom_range(0, 2) != 0;
			end
			if (notes == 5) begin
				// The receiver holds off while short notes keep coming, so the result
				// register fills and the next final byte backs up into the input.
				sink_hold_req = 1'b1;
				repeat (8) begin
					build_noise(3);
					send_note();
				end
				build_frame(pick_weight());
				send_note();
				wait_all_answered();
			end
			build_random_note();
			send_note();
			notes++;
		end

		wait_all_answered();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- scale_weight_frame_decoder.f -----
rtl/swfd_pkg.sv
rtl/swfd_in_stage.sv
rtl/swfd_frame_check.sv
rtl/swfd_out_stage.sv
rtl/scale_weight_frame_decoder.sv
tb/sv/scale_weight_frame_decoder_checker.sv
tb/sv/scale_weight_frame_decoder_tb.sv
